### src/uart_pkg.sv
`default_nettype none

package uart_pkg;

  localparam int DEF_MAX_DATA_BITS = 8;
  localparam int DEF_COUNT_WIDTH   = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_BIT_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_BITS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_BITS = 2'd2;

  localparam logic [15:0] RST_BIT_TICKS = 16'd16;
  localparam logic [3:0]  RST_DATA_BITS = 4'd8;
  localparam logic [1:0]  RST_STOP_BITS = 2'd1;

  localparam logic [3:0]  MIN_DATA_BITS = 4'd5;
  localparam logic [1:0]  MIN_STOP_BITS = 2'd1;
  localparam logic [1:0]  MAX_STOP_BITS = 2'd2;
  localparam logic [15:0] MIN_BIT_TICKS = 16'd2;

  typedef struct packed {
    logic [15:0] bit_ticks;
    logic [3:0]  char_len;
    logic [1:0]  stop_len;
  } cfg_t;

  typedef enum logic [1:0] {
    TX_IDLE  = 2'd0,
    TX_START = 2'd1,
    TX_DATA  = 2'd2,
    TX_STOP  = 2'd3
  } tx_phase_t;

  typedef enum logic [2:0] {
    RX_IDLE  = 3'd0,
    RX_START = 3'd1,
    RX_DATA  = 3'd2,
    RX_STOP  = 3'd3,
    RX_WAIT  = 3'd4
  } rx_phase_t;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       frame_error;
  } rx_result_t;

endpackage

`default_nettype wire

### src/uart_transceiver_top.sv
`default_nettype none

// Full-duplex UART driven by timing ticks: every input transfer is one tick
// that carries the sampled receive line and an optional byte to send, and it
// produces exactly one result transfer with the transmit line level, the
// busy flag and any received byte for that tick. One tick is accepted in
// every clock cycle except while the output register is full and stalled, the
// only case in which the input side stalls; the result is registered as its
// tick is taken. Transmitter and receiver update their counters and shift
// registers combinationally. The receiver samples each data and stop bit at
// its middle tick, reports at the middle of the last stop bit, and after a
// low stop bit flags a frame error and waits for the line to return high.
// Configuration writes are taken at any time but should only be made while
// no tick is in flight; they take effect on the next tick.
module uart_transceiver_top #(
  parameter int MAX_DATA_BITS = uart_pkg::DEF_MAX_DATA_BITS,
  parameter int COUNT_WIDTH   = uart_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,

  input  wire logic                             cfg_write,
  input  wire logic [uart_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [uart_pkg::CFG_DATA_W-1:0]  cfg_data,

  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             rx_line,
  input  wire logic                             tx_start,
  input  wire logic [7:0]                       tx_byte,

  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  tx_line,
  output logic                                  tx_busy,
  output logic                                  rx_valid,
  output logic [7:0]                            rx_byte,
  output logic                                  rx_frame_error
);
  import uart_pkg::*;

  cfg_t       cfg;
  logic       advance;
  tx_result_t tx_res;
  rx_result_t rx_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_ticks <= RST_BIT_TICKS;
      cfg.char_len  <= RST_DATA_BITS;
      cfg.stop_len  <= RST_STOP_BITS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BIT_TICKS: cfg.bit_ticks <= cfg_data;
        REG_DATA_BITS: cfg.char_len  <= cfg_data[3:0];
        REG_STOP_BITS: cfg.stop_len  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = out_valid & out_stall;
  assign advance  = in_valid & ~in_stall;

  uart_tx #(
    .MAX_DATA_BITS (MAX_DATA_BITS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_tx (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .cfg      (cfg),
    .tx_start (tx_start),
    .tx_byte  (tx_byte),
    .result   (tx_res)
  );

  uart_rx #(
    .MAX_DATA_BITS (MAX_DATA_BITS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_rx (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .rx_line (rx_line),
    .result  (rx_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_line        <= tx_res.line;
      tx_busy        <= tx_res.busy;
      rx_valid       <= rx_res.valid;
      rx_byte        <= rx_res.data;
      rx_frame_error <= rx_res.frame_error;
    end
  end

endmodule

`default_nettype wire

### src/uart_tx.sv
`default_nettype none

module uart_tx #(
  parameter int MAX_DATA_BITS = uart_pkg::DEF_MAX_DATA_BITS,
  parameter int COUNT_WIDTH   = uart_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire uart_pkg::cfg_t    cfg,
  input  wire logic              tx_start,
  input  wire logic [7:0]        tx_byte,
  output uart_pkg::tx_result_t   result
);
  import uart_pkg::*;

  localparam int TW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [TW-1:0]          bt_w;
  logic [TW-1:0]          cmax_w;
  logic [TW-1:0]          t_w;
  logic [COUNT_WIDTH-1:0] ticks;
  logic [3:0]             dbits;
  logic [1:0]             sbits;

  tx_phase_t              phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [3:0]             bit_index, bit_index_next;
  logic [7:0]             shift, shift_next;
  logic [3:0]             idx_inc;

  assign bt_w   = TW'(cfg.bit_ticks);
  assign cmax_w = TW'({COUNT_WIDTH{1'b1}});

  always_comb begin
    t_w = bt_w;
    if (t_w < TW'(MIN_BIT_TICKS)) t_w = TW'(MIN_BIT_TICKS);
    if (t_w > cmax_w) t_w = cmax_w;
    ticks = t_w[COUNT_WIDTH-1:0];

    dbits = cfg.char_len;
    if (dbits < MIN_DATA_BITS) dbits = MIN_DATA_BITS;
    if (dbits > 4'(MAX_DATA_BITS)) dbits = 4'(MAX_DATA_BITS);

    sbits = cfg.stop_len;
    if (sbits < MIN_STOP_BITS) sbits = MIN_STOP_BITS;
    if (sbits > MAX_STOP_BITS) sbits = MAX_STOP_BITS;
  end

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_next      = shift;
    result.line     = 1'b1;
    result.busy     = 1'b0;

    // A request is taken only when idle; the start bit goes out on the same tick.
    if (phase == TX_IDLE && tx_start) begin
      phase_next      = TX_START;
      tick_count_next = '0;
      bit_index_next  = '0;
      shift_next      = tx_byte;
    end

    idx_inc = bit_index_next + 4'd1;

    if (phase_next != TX_IDLE) begin
      result.busy = 1'b1;
      case (phase_next)
        TX_START: result.line = 1'b0;
        TX_DATA: begin
          result.line = bit_index_next[3] ? 1'b0 : shift_next[bit_index_next[2:0]];
        end
        default: result.line = 1'b1;
      endcase

      tick_count_next = tick_count_next + 1'b1;
      if (tick_count_next >= ticks) begin
        tick_count_next = '0;
        case (phase_next)
          TX_START: begin
            phase_next     = TX_DATA;
            bit_index_next = '0;
          end
          TX_DATA: begin
            bit_index_next = idx_inc;
            if (idx_inc >= dbits) begin
              phase_next     = TX_STOP;
              bit_index_next = '0;
            end
          end
          default: begin
            bit_index_next = idx_inc;
            if (idx_inc >= 4'(sbits)) begin
              phase_next     = TX_IDLE;
              bit_index_next = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= TX_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift      <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift      <= shift_next;
    end
  end

endmodule

`default_nettype wire

### src/uart_rx.sv
`default_nettype none

module uart_rx #(
  parameter int MAX_DATA_BITS = uart_pkg::DEF_MAX_DATA_BITS,
  parameter int COUNT_WIDTH   = uart_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire uart_pkg::cfg_t    cfg,
  input  wire logic              rx_line,
  output uart_pkg::rx_result_t   result
);
  import uart_pkg::*;

  localparam int TW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [TW-1:0]          bt_w;
  logic [TW-1:0]          cmax_w;
  logic [TW-1:0]          t_w;
  logic [COUNT_WIDTH-1:0] ticks;
  logic [3:0]             dbits;
  logic [1:0]             sbits;

  rx_phase_t              phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [3:0]             bit_index, bit_index_next;
  logic [7:0]             shift, shift_next;
  logic [3:0]             idx_inc;
  logic                   done;

  assign bt_w   = TW'(cfg.bit_ticks);
  assign cmax_w = TW'({COUNT_WIDTH{1'b1}});

  always_comb begin
    t_w = bt_w;
    if (t_w < TW'(MIN_BIT_TICKS)) t_w = TW'(MIN_BIT_TICKS);
    if (t_w > cmax_w) t_w = cmax_w;
    ticks = t_w[COUNT_WIDTH-1:0];

    dbits = cfg.char_len;
    if (dbits < MIN_DATA_BITS) dbits = MIN_DATA_BITS;
    if (dbits > 4'(MAX_DATA_BITS)) dbits = 4'(MAX_DATA_BITS);

    sbits = cfg.stop_len;
    if (sbits < MIN_STOP_BITS) sbits = MIN_STOP_BITS;
    if (sbits > MAX_STOP_BITS) sbits = MAX_STOP_BITS;
  end

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_next         = shift;
    result.valid       = 1'b0;
    result.data        = '0;
    result.frame_error = 1'b0;
    done               = 1'b0;
    idx_inc            = '0;

    if (phase == RX_WAIT) begin
      if (rx_line) phase_next = RX_IDLE;
    end else begin
      if (phase == RX_IDLE && !rx_line) begin
        phase_next      = RX_START;
        tick_count_next = '0;
        bit_index_next  = '0;
        shift_next      = '0;
      end

      idx_inc = bit_index_next + 4'd1;

      if (phase_next == RX_START || phase_next == RX_DATA || phase_next == RX_STOP) begin
        // Every bit after the start bit is sampled at its middle tick.
        if (tick_count_next == (ticks >> 1)) begin
          if (phase_next == RX_DATA) begin
            if (!bit_index_next[3]) begin
              shift_next[bit_index_next[2:0]] = shift_next[bit_index_next[2:0]] | rx_line;
            end
          end else if (phase_next == RX_STOP) begin
            if (!rx_line) begin
              result.valid       = 1'b1;
              result.frame_error = 1'b1;
              result.data        = shift_next;
              phase_next         = RX_WAIT;
              done               = 1'b1;
            end else if (idx_inc >= 4'(sbits)) begin
              result.valid = 1'b1;
              result.data  = shift_next;
              phase_next   = RX_IDLE;
              done         = 1'b1;
            end
          end
        end

        if (!done) begin
          tick_count_next = tick_count_next + 1'b1;
          if (tick_count_next >= ticks) begin
            tick_count_next = '0;
            case (phase_next)
              RX_START: begin
                phase_next     = RX_DATA;
                bit_index_next = '0;
              end
              RX_DATA: begin
                bit_index_next = idx_inc;
                if (idx_inc >= dbits) begin
                  phase_next     = RX_STOP;
                  bit_index_next = '0;
                end
              end
              default: begin
                bit_index_next = idx_inc;
                if (idx_inc >= 4'(sbits)) begin
                  phase_next     = RX_IDLE;
                  bit_index_next = '0;
                end
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= RX_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift      <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift      <= shift_next;
    end
  end

endmodule

`default_nettype wire

### verif/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uart_pkg::*;

  localparam int IDLE_PCT     = 26;
  localparam int TX_START_PCT = 10;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE       = 4;
  localparam int RANDOM_TICKS = 900;
  localparam int CYCLE_LIMIT  = 300000;

  // The index space has one code that maps to no register.
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic       line;
    logic       busy;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_err;
  } tick_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       rx_line  = 1'b1;
  logic       tx_start = 1'b0;
  logic [7:0] tx_byte  = 8'h00;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       tx_line;
  logic       tx_busy;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       rx_frame_error;

  uart_transceiver_top u_dut (.*);

  initial forever #6 clk = ~clk;

  // Register copies and the transceiver state as the block should hold them.
  logic [15:0] cfg_ticks = RST_BIT_TICKS;
  logic [3:0]  cfg_dbits = RST_DATA_BITS;
  logic [1:0]  cfg_sbits = RST_STOP_BITS;

  tx_phase_t   tx_ph  = TX_IDLE;
  logic [15:0] tx_cnt = '0;
  logic [3:0]  tx_idx = '0;
  logic [7:0]  tx_sh  = '0;
  rx_phase_t   rx_ph  = RX_IDLE;
  logic [15:0] rx_cnt = '0;
  logic [3:0]  rx_idx = '0;
  logic [7:0]  rx_sh  = '0;

  tick_out_t uart_outputs_q[$];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  ticks_sent   = 0;
  int  cycle_count  = 0;
  int  hold_cnt     = 0;
  bit  hold_arm     = 1'b0;
  bit  steady       = 1'b0;

  function automatic logic [15:0] eff_ticks();
    return (cfg_ticks < MIN_BIT_TICKS) ? MIN_BIT_TICKS : cfg_ticks;
  endfunction

  function automatic logic [3:0] eff_dbits();
    if (cfg_dbits < MIN_DATA_BITS) return MIN_DATA_BITS;
    if (cfg_dbits > 4'(DEF_MAX_DATA_BITS)) return 4'(DEF_MAX_DATA_BITS);
    return cfg_dbits;
  endfunction

  function automatic logic [1:0] eff_sbits();
    if (cfg_sbits < MIN_STOP_BITS) return MIN_STOP_BITS;
    if (cfg_sbits > MAX_STOP_BITS) return MAX_STOP_BITS;
    return cfg_sbits;
  endfunction

  // Advances both halves of the link by one tick and returns its outputs.
  function automatic tick_out_t uart_tick(input logic line, input logic start,
                                          input logic [7:0] data);
    tick_out_t   r;
    logic [15:0] t;
    logic [3:0]  d;
    logic [1:0]  s;
    logic        done;
    t = eff_ticks();
    d = eff_dbits();
    s = eff_sbits();
    r = '{line: 1'b1, busy: 1'b0, rx_valid: 1'b0, rx_byte: 8'h00, rx_err: 1'b0};

    if (tx_ph == TX_IDLE && start) begin
      tx_ph  = TX_START;
      tx_cnt = '0;
      tx_idx = '0;
      tx_sh  = data;
    end
    if (tx_ph != TX_IDLE) begin
      r.busy = 1'b1;
      case (tx_ph)
        TX_START: r.line = 1'b0;
        TX_DATA:  r.line = (tx_idx < 4'd8) ? tx_sh[tx_idx[2:0]] : 1'b0;
        default:  r.line = 1'b1;
      endcase
      tx_cnt = tx_cnt + 16'd1;
      if (tx_cnt >= t) begin
        tx_cnt = '0;
        case (tx_ph)
          TX_START: begin
            tx_ph  = TX_DATA;
            tx_idx = '0;
          end
          TX_DATA: begin
            tx_idx = tx_idx + 4'd1;
            if (tx_idx >= d) begin
              tx_ph  = TX_STOP;
              tx_idx = '0;
            end
          end
          default: begin
            tx_idx = tx_idx + 4'd1;
            if (tx_idx >= {2'b00, s}) begin
              tx_ph  = TX_IDLE;
              tx_idx = '0;
            end
          end
        endcase
      end
    end

    if (rx_ph == RX_WAIT) begin
      if (line) rx_ph = RX_IDLE;
    end else begin
      if (rx_ph == RX_IDLE && !line) begin
        rx_ph  = RX_START;
        rx_cnt = '0;
        rx_idx = '0;
        rx_sh  = '0;
      end
      if (rx_ph != RX_IDLE) begin
        done = 1'b0;
        if (rx_cnt == (t >> 1)) begin
          if (rx_ph == RX_DATA) begin
            if (rx_idx < 4'd8) rx_sh[rx_idx[2:0]] = rx_sh[rx_idx[2:0]] | line;
          end else if (rx_ph == RX_STOP) begin
            if (!line) begin
              r.rx_valid = 1'b1;
              r.rx_err   = 1'b1;
              r.rx_byte  = rx_sh;
              rx_ph      = RX_WAIT;
              done       = 1'b1;
            end else if ({1'b0, rx_idx} + 5'd1 >= {3'b000, s}) begin
              r.rx_valid = 1'b1;
              r.rx_byte  = rx_sh;
              rx_ph      = RX_IDLE;
              done       = 1'b1;
            end
          end
        end
        if (!done) begin
          rx_cnt = rx_cnt + 16'd1;
          if (rx_cnt >= t) begin
            rx_cnt = '0;
            case (rx_ph)
              RX_START: begin
                rx_ph  = RX_DATA;
                rx_idx = '0;
              end
              RX_DATA: begin
                rx_idx = rx_idx + 4'd1;
                if (rx_idx >= d) begin
                  rx_ph  = RX_STOP;
                  rx_idx = '0;
                end
              end
              default: begin
                rx_idx = rx_idx + 4'd1;
                if (rx_idx >= {2'b00, s}) begin
                  rx_ph  = RX_IDLE;
                  rx_idx = '0;
                end
              end
            endcase
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  // Output side: stall pattern, with a counted hold-off when one is armed.
  always @(negedge clk) begin
    if (hold_arm) begin
      hold_arm = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    tick_out_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{line: tx_line, busy: tx_busy, rx_valid: rx_valid, rx_byte: rx_byte,
              rx_err: rx_frame_error};
      if (uart_outputs_q.size() == 0) begin
        report_mismatch("result transfer with no tick outstanding");
      end else begin
        want = uart_outputs_q.pop_front();
        if (got.line !== want.line)
          report_mismatch($sformatf("tx_line %b, want %b", got.line, want.line));
        if (got.busy !== want.busy)
          report_mismatch($sformatf("tx_busy %b, want %b", got.busy, want.busy));
        if (got.rx_valid !== want.rx_valid)
          report_mismatch($sformatf("rx_valid %b, want %b", got.rx_valid, want.rx_valid));
        if (got.rx_byte !== want.rx_byte)
          report_mismatch($sformatf("rx_byte %h, want %h", got.rx_byte, want.rx_byte));
        if (got.rx_err !== want.rx_err)
          report_mismatch($sformatf("rx_frame_error %b, want %b", got.rx_err, want.rx_err));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("uart_transceiver_top verification failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(input logic line, input logic start, input logic [7:0] data);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_line  <= line;
    tx_start <= start;
    tx_byte  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    uart_outputs_q.push_back(uart_tick(line, start, data));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Holds the receive line for n ticks while the transmit side gets random requests.
  task automatic drive_line(input logic level, input int n);
    repeat (n) send_tick(level, $urandom_range(99) < TX_START_PCT, 8'($urandom));
  endtask

  // One serial frame on the receive line at the current settings; bad_stop picks
  // a stop bit to pull low, or none when negative.
  task automatic send_frame(input logic [7:0] data, input int bad_stop);
    int t, d, s;
    t = int'(eff_ticks());
    d = int'(eff_dbits());
    s = int'(eff_sbits());
    drive_line(1'b0, t);
    for (int i = 0; i < d; i++) drive_line(data[i], t);
    for (int j = 0; j < s; j++) drive_line((j == bad_stop) ? 1'b0 : 1'b1, t);
    if (bad_stop >= 0) begin
      drive_line(1'b0, $urandom_range(0, t));
      drive_line(1'b1, 1 + $urandom_range(0, t));
    end
  endtask

  task automatic await_results();
    in_valid <= 1'b0;
    while (uart_outputs_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_BIT_TICKS: cfg_ticks = val;
      REG_DATA_BITS: cfg_dbits = val[3:0];
      REG_STOP_BITS: cfg_sbits = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // The stall process reads this flag at falling edges, so it changes at a rising one.
  // The input side is idle meanwhile so that the last tick is not offered again.
  task automatic set_steady(input bit v);
    in_valid <= 1'b0;
    @(posedge clk);
    steady = v;
    @(negedge clk);
  endtask

  task automatic test_directed_frames();
    drive_line(1'b1, 2);
    await_results();
    write_reg(REG_BIT_TICKS, 16'd2);
    write_reg(REG_DATA_BITS, 16'd5);
    write_reg(REG_STOP_BITS, 16'd1);
    send_tick(1'b1, 1'b1, 8'hFF);
    // A second request while the first frame is on the line must be dropped.
    send_tick(1'b1, 1'b1, 8'h00);
    send_frame(8'h00, -1);
    send_frame(8'hFF, 0);
    await_results();
  endtask

  task automatic test_register_limits();
    write_reg(REG_BIT_TICKS, 16'hFFFF);
    write_reg(REG_DATA_BITS, 16'hFFFF);
    write_reg(REG_STOP_BITS, 16'hFFFF);
    send_tick(1'b0, 1'b1, 8'hA5);
    drive_line(1'b0, 15);
    await_results();
    // Shrinking the bit period mid-bit closes the current bit on the next tick.
    write_reg(REG_BIT_TICKS, 16'h0000);
    write_reg(REG_DATA_BITS, 16'h0000);
    write_reg(REG_STOP_BITS, 16'h0000);
    write_reg(REG_NONE, 16'h5A5A);
    drive_line(1'b1, 20);
    send_frame(8'($urandom), -1);
    await_results();
    write_reg(REG_BIT_TICKS, 16'h0001);
    write_reg(REG_DATA_BITS, 16'h0009);
    write_reg(REG_STOP_BITS, 16'h0002);
    send_frame(8'h5A, 1);
    drive_line(1'b1, 4);
    await_results();
  endtask

  task automatic test_random_traffic();
    int goal, phase, t, d, s, k;
    logic [15:0] ticks_val;
    goal  = ticks_sent + RANDOM_TICKS;
    phase = 0;
    while (ticks_sent < goal) begin
      phase++;
      await_results();
      case ($urandom_range(9))
        0:       ticks_val = 16'($urandom_range(1));
        1:       ticks_val = 16'd16;
        default: ticks_val = 16'($urandom_range(2, 6));
      endcase
      write_reg(REG_BIT_TICKS, ticks_val);
      write_reg(REG_DATA_BITS, {12'($urandom),
        ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5, 8))});
      write_reg(REG_STOP_BITS, {14'($urandom), 2'($urandom_range(3))});
      if ($urandom_range(3) == 0) write_reg(REG_NONE, 16'($urandom));
      t = int'(eff_ticks());
      d = int'(eff_dbits());
      s = int'(eff_sbits());
      if (phase == 3) set_steady(1'b1);
      repeat ($urandom_range(3, 6)) begin
        drive_line(1'b1, $urandom_range(0, 2 * t));
        k = $urandom_range(99);
        if (k < 70) begin
          send_frame(8'($urandom), -1);
        end else if (k < 85) begin
          send_frame(8'($urandom), $urandom_range(0, s - 1));
        end else begin
          repeat ($urandom_range(1, 3 * t)) drive_line(1'($urandom_range(1)), 1);
          drive_line(1'b1, (1 + d + s) * t);
        end
      end
      if (phase == 3) set_steady(1'b0);
    end
    await_results();
  endtask

  task automatic test_backpressure();
    write_reg(REG_BIT_TICKS, 16'd2);
    write_reg(REG_DATA_BITS, 16'd8);
    write_reg(REG_STOP_BITS, 16'd2);
    set_steady(1'b1);
    @(posedge clk);
    hold_arm = 1'b1;
    @(negedge clk);
    // The sender keeps a tick on offer the whole time the output side is held.
    send_frame(8'($urandom), -1);
    send_frame(8'($urandom), -1);
    set_steady(1'b0);
    await_results();
    send_frame(8'($urandom), 1);
    drive_line(1'b1, 3);
    await_results();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_frames();
    test_register_limits();
    test_random_traffic();
    test_backpressure();
    await_results();
    if (mismatches == 0) begin
      $display("uart_transceiver_top verification clean");
    end else begin
      $display("uart_transceiver_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/uart_pkg.sv
src/uart_tx.sv
src/uart_rx.sv
src/uart_transceiver_top.sv
verif/tb.sv
